### design/mpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and constants for the mask pattern pixel adjust pipeline.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int ChanW    = 8;
  localparam int DesatW   = 9;
  localparam int WhiteW   = 10;
  localparam int BlackW   = 8;
  localparam int NumLanes = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Product widths along a lane
  localparam int PullProdW  = ChanW + DesatW;    // (peak - c) * desaturation
  localparam int LevelW     = ChanW + 2;         // c + pull, at most 509
  localparam int GainProdW  = LevelW + WhiteW;   // level * white_level
  localparam int ScaledW    = GainProdW - 8;     // after the /256
  localparam int SpanW      = BlackW + 1;        // 256 - black_level
  localparam int CompProdW  = ChanW + SpanW;     // n * (256 - black_level)

  localparam logic [ChanW-1:0] ChanMax   = 8'd255;
  localparam logic [SpanW-1:0] FullSpan  = 9'd256;
  localparam logic [DesatW-1:0] DesatFull = 9'd256;
  localparam logic [WhiteW-1:0] WhiteUnity = 10'd256;

  localparam logic [DesatW-1:0] DesatReset = 9'd0;
  localparam logic [WhiteW-1:0] WhiteReset = 10'd256;
  localparam logic [BlackW-1:0] BlackReset = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaskOnly = 2'd0,
    CfgDesat    = 2'd1,
    CfgWhite    = 2'd2,
    CfgBlack    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic              mask_only_mode;
    logic [DesatW-1:0] desaturation;
    logic [WhiteW-1:0] white_level;
    logic [BlackW-1:0] black_level;
  } cfg_t;

  // One channel as handed from the front stage to a lane
  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [ChanW-1:0] peak;
    logic             pull;
    logic             bypass;
  } lane_in_t;

  // Pipeline advance and per-stage occupancy, driven by the merge stage
  typedef struct packed {
    logic adv;
    logic v1;
    logic v2;
    logic v3;
  } pipe_ctl_t;

endpackage

### design/mask_pattern_pixel_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_pattern_pixel_adjust
// A result passes the front register, the lane stages and the output register
// before it is offered. Throughput: one pixel per cycle while the output is not
// stalled; three channel lanes, one multiplier each per stage, five register stages in all.
// Backpressure stalls the whole pipe; in_ready_o follows the output register.
// Reset clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module mask_pattern_pixel_adjust (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mpa_pkg::pix_in_t             in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mpa_pkg::pix_out_t            out_o,
  input  logic                         cfg_we_i,
  input  logic [mpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpa_pkg::CfgDataW-1:0] cfg_data_i
);

  mpa_pkg::cfg_t             cfg_d, cfg_q;
  mpa_pkg::pipe_ctl_t        ctl;
  mpa_pkg::lane_in_t         lane [mpa_pkg::NumLanes];
  logic [mpa_pkg::ChanW-1:0] res  [mpa_pkg::NumLanes];
  logic                      v0;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mpa_pkg::cfg_idx_e'(cfg_idx_i))
        mpa_pkg::CfgMaskOnly: cfg_d.mask_only_mode = cfg_data_i[0];
        mpa_pkg::CfgDesat:    cfg_d.desaturation   = cfg_data_i[mpa_pkg::DesatW-1:0];
        mpa_pkg::CfgWhite:    cfg_d.white_level    = cfg_data_i[mpa_pkg::WhiteW-1:0];
        mpa_pkg::CfgBlack:    cfg_d.black_level    = cfg_data_i[mpa_pkg::BlackW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_only_mode <= 1'b0;
      cfg_q.desaturation   <= mpa_pkg::DesatReset;
      cfg_q.white_level    <= mpa_pkg::WhiteReset;
      cfg_q.black_level    <= mpa_pkg::BlackReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = ctl.adv;

  mpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (ctl.adv),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .mask_only_i (cfg_q.mask_only_mode),
    .v0_o        (v0),
    .lane_o      (lane)
  );

  for (genvar g = 0; g < mpa_pkg::NumLanes; g++) begin : g_lane
    mpa_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cfg_i  (cfg_q),
      .lane_i (lane[g]),
      .res_o  (res[g])
    );
  end

  mpa_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .v0_i        (v0),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

### design/mpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_front
// Input stage: finds the peak channel, marks channels to pull and the
// pass-through case, and registers one lane record per channel.
// ----------------------------------------------------------------------------
module mpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  mpa_pkg::pix_in_t    in_i,
  input  logic                mask_only_i,
  output logic                v0_o,
  output mpa_pkg::lane_in_t   lane_o [mpa_pkg::NumLanes]
);

  logic [mpa_pkg::ChanW-1:0] ch [mpa_pkg::NumLanes];
  logic [mpa_pkg::ChanW-1:0] peak;
  logic                      bypass;
  logic                      v0_q;
  mpa_pkg::lane_in_t         lane_d [mpa_pkg::NumLanes];
  mpa_pkg::lane_in_t         lane_q [mpa_pkg::NumLanes];

  assign ch[0] = in_i.red_in;
  assign ch[1] = in_i.green_in;
  assign ch[2] = in_i.blue_in;

  always_comb begin
    peak = ch[0];
    if (ch[1] > peak) peak = ch[1];
    if (ch[2] > peak) peak = ch[2];
  end

  assign bypass = mask_only_i && (in_i.alpha_in == '0);

  // A gray pixel has every channel at the peak, so nothing is pulled.
  always_comb begin
    for (int z = 0; z < mpa_pkg::NumLanes; z++) begin
      lane_d[z].chan   = ch[z];
      lane_d[z].peak   = peak;
      lane_d[z].pull   = (ch[z] != peak);
      lane_d[z].bypass = bypass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign v0_o   = v0_q;
  assign lane_o = lane_q;

endmodule

### design/mpa_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_lane
// One channel's arithmetic: desaturation pull, gain with saturation and
// black-level compression, one multiplier per stage.
// ----------------------------------------------------------------------------
module mpa_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mpa_pkg::pipe_ctl_t        ctl_i,
  input  mpa_pkg::cfg_t             cfg_i,
  input  mpa_pkg::lane_in_t         lane_i,
  output logic [mpa_pkg::ChanW-1:0] res_o
);

  // stage 1: pull product
  logic [mpa_pkg::ChanW-1:0]     diff;
  logic [mpa_pkg::PullProdW-1:0] prod1_d, prod1_q;
  logic [mpa_pkg::ChanW-1:0]     chan1_q;
  logic                          byp1_q;

  // stage 2: gain product
  logic [mpa_pkg::LevelW-1:0]    level;
  logic [mpa_pkg::GainProdW-1:0] prod2_d, prod2_q;
  logic [mpa_pkg::ChanW-1:0]     chan2_q;
  logic                          byp2_q;

  // stage 3: black-level compression
  logic [mpa_pkg::ScaledW-1:0]   scaled;
  logic [mpa_pkg::SpanW-1:0]     span;
  logic [mpa_pkg::CompProdW-1:0] prod3;
  logic                          sat3_d, sat3_q;
  logic [mpa_pkg::ChanW-1:0]     frac3_q;
  logic [mpa_pkg::ChanW-1:0]     chan3_q;
  logic                          byp3_q;

  assign diff    = lane_i.peak - lane_i.chan;
  assign prod1_d = lane_i.pull
                 ? (mpa_pkg::PullProdW'(diff) * mpa_pkg::PullProdW'(cfg_i.desaturation))
                 : '0;

  assign level   = mpa_pkg::LevelW'(chan1_q)
                 + mpa_pkg::LevelW'(prod1_q[mpa_pkg::PullProdW-1:8]);
  assign prod2_d = mpa_pkg::GainProdW'(level) * mpa_pkg::GainProdW'(cfg_i.white_level);

  assign scaled  = prod2_q[mpa_pkg::GainProdW-1:8];
  assign sat3_d  = |scaled[mpa_pkg::ScaledW-1:mpa_pkg::ChanW];
  assign span    = mpa_pkg::FullSpan - mpa_pkg::SpanW'(cfg_i.black_level);
  // n * span stays below 2^16 for n <= 255
  assign prod3   = mpa_pkg::CompProdW'(scaled[mpa_pkg::ChanW-1:0])
                 * mpa_pkg::CompProdW'(span);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      prod1_q <= prod1_d;
      chan1_q <= lane_i.chan;
      byp1_q  <= lane_i.bypass;
      prod2_q <= prod2_d;
      chan2_q <= chan1_q;
      byp2_q  <= byp1_q;
      sat3_q  <= sat3_d;
      frac3_q <= prod3[2*mpa_pkg::ChanW-1:mpa_pkg::ChanW];
      chan3_q <= chan2_q;
      byp3_q  <= byp2_q;
    end
  end

  always_comb begin
    if (byp3_q) begin
      res_o = chan3_q;
    end else if (sat3_q) begin
      res_o = mpa_pkg::ChanMax;
    end else begin
      res_o = cfg_i.black_level + frac3_q;
    end
  end

  // Compression never wraps below the black level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.v3 && !byp3_q && !sat3_q) |-> (res_o >= cfg_i.black_level))
    else $error("mpa_lane: compressed value wrapped below black level");

  // Pull of at most full strength and gain of at most unity cannot saturate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.v2 && !byp2_q && cfg_i.desaturation <= mpa_pkg::DesatFull
     && cfg_i.white_level <= mpa_pkg::WhiteUnity)
    |-> (prod2_q[mpa_pkg::GainProdW-1:16] == '0))
    else $error("mpa_lane: unexpected saturation at unity gain");

endmodule

### design/mpa_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_merge
// Tracks stage occupancy, drives the pipeline advance and gathers the
// three lane results into the registered output transaction.
// ----------------------------------------------------------------------------
module mpa_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      v0_i,
  input  logic [mpa_pkg::ChanW-1:0] res_i [mpa_pkg::NumLanes],
  input  logic                      out_ready_i,
  output mpa_pkg::pipe_ctl_t        ctl_o,
  output logic                      out_valid_o,
  output mpa_pkg::pix_out_t         out_o
);

  logic              v1_q, v2_q, v3_q, out_vld_q;
  logic              adv;
  mpa_pkg::pix_out_t out_d, out_q;

  // The whole pipe moves unless a finished pixel sits unclaimed at the output.
  assign adv = !out_vld_q || out_ready_i;

  assign out_d.red_out   = res_i[0];
  assign out_d.green_out = res_i[1];
  assign out_d.blue_out  = res_i[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= v0_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      out_vld_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign ctl_o.adv   = adv;
  assign ctl_o.v1    = v1_q;
  assign ctl_o.v2    = v2_q;
  assign ctl_o.v3    = v3_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // A held pipe keeps every stage's occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, out_vld_q}))
    else $error("mpa_merge: stage occupancy changed during stall");

  // A pixel in the last lane stage reaches the output when the pipe moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> out_vld_q)
    else $error("mpa_merge: pixel lost between last stage and output");

  // Stage 1 is loaded only from the front stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !v0_i) |=> !v1_q)
    else $error("mpa_merge: stage 1 filled without a transaction");

endmodule
